>>> hw/rtl/ual_pkg.sv
// ual_pkg: field widths, action codes and status codes of the unique array list
// used by unique_array_list; no dependencies

package ual_pkg;

    localparam int ACTION_W = 3;
    localparam int KEY_BITS = 32;
    localparam int COUNT_W  = 8;
    localparam int STATUS_W = 3;
    localparam int OUT_W    = 48;
    localparam int OUT_PAD  = OUT_W - KEY_BITS - 1 - COUNT_W - STATUS_W;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_NEXT   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_REWIND = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

endpackage

>>> hw/rtl/unique_array_list.sv
// unique_array_list: packed list of distinct keys with count and read position
// depends on ual_pkg and ual_ram
//
// usage
// - s_* carries one request: s_tuser is the action (insert, delete, next, clear,
//   rewind), s_tdata the key; a request is taken when s_tvalid and s_tready are high
// - m_* returns exactly one result per request: key, found flag, count, status
// - one request is worked on at a time; s_tready is high while the block is idle,
//   also while the previous result still waits in the output register
// - insert and delete search the key ram with one read per cycle
// - a delete that hits then shifts the later entries down, one per cycle
// - next does one ram read
// - the ram read port is registered
// - reset empties the list and rewinds the read position; the ram is not cleared,
//   entries at or above the count are never read
// - if m_tready is low the result holds on m_tdata and the block waits in its
//   final step until the output register frees up

module unique_array_list
    import ual_pkg::*;
#(
    parameter int CAPACITY  = 128,
    parameter int KEY_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [KEY_BITS-1:0] s_tdata,   // key
    input  logic [ACTION_W-1:0] s_tuser,   // action
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata    // key_out, found, count_out, status, zero pad
);

    localparam int SW = (KEY_WIDTH < KEY_BITS) ? KEY_WIDTH : KEY_BITS;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = $clog2(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_NEXT,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [ACTION_W-1:0] act_reg, act_next;
    logic [SW-1:0]       key_reg, key_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic [CW-1:0]       rd_idx_reg, rd_idx_next;
    logic [CW-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [KEY_BITS-1:0] res_key_reg, res_key_next;
    logic                res_found_reg, res_found_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                m_valid_reg, m_valid_next;
    logic [KEY_BITS-1:0] out_key_reg, out_key_next;
    logic                out_found_reg, out_found_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    logic                wr_en;
    logic [PW-1:0]       wr_addr;
    logic [SW-1:0]       wr_data;
    logic                rd_en;
    logic [PW-1:0]       rd_addr;
    logic [SW-1:0]       rd_data;

    logic                accept;
    logic                out_free;
    logic [CW-1:0]       pos_ext;
    logic [CW-1:0]       pos_start;
    logic [CW-1:0]       pos_inc;
    logic [CW-1:0]       shift_dst;
    logic [CW+COUNT_W-1:0] count_wide;

    ual_ram #(
        .WIDTH (SW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_valid_reg || m_tready;
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {{OUT_PAD{1'b0}}, out_status_reg, out_count_reg,
                         out_found_reg, out_key_reg};

    assign pos_ext    = CW'(pos_reg);
    assign pos_start  = (pos_ext >= count_reg) ? '0 : pos_ext;
    assign pos_inc    = pos_start + CW'(1);
    assign shift_dst  = cmp_idx_reg - CW'(1);
    assign count_wide = {{COUNT_W{1'b0}}, count_reg};

    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        key_next        = key_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        rd_idx_next     = rd_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_valid_next  = 1'b0;
        res_key_next    = res_key_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_key_next    = out_key_reg;
        out_found_next  = out_found_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[PW-1:0];
        wr_data         = key_reg;
        rd_en           = 1'b0;
        rd_addr         = rd_idx_reg[PW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    act_next        = s_tuser;
                    key_next        = s_tdata[SW-1:0];
                    res_key_next    = '0;
                    res_found_next  = 1'b0;
                    res_status_next = ST_OK;
                    rd_idx_next     = '0;
                    state_next      = S_DONE;
                    unique case (s_tuser)
                        ACT_INSERT, ACT_DELETE:
                        begin
                            state_next = S_SEARCH;
                        end
                        ACT_NEXT:
                        begin
                            if (count_reg == '0)
                            begin
                                pos_next        = '0;
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = pos_start[PW-1:0];
                                pos_next   = (pos_inc >= count_reg) ? '0 : pos_inc[PW-1:0];
                                state_next = S_NEXT;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                        end
                        ACT_REWIND:
                        begin
                            pos_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_NEXT:
            begin
                res_key_next = KEY_BITS'(rd_data);
                state_next   = S_DONE;
            end

            S_SEARCH:
            begin
                if (cmp_valid_reg && (rd_data == key_reg))
                begin
                    res_key_next   = KEY_BITS'(rd_data);
                    res_found_next = 1'b1;
                    if (act_reg == ACT_INSERT)
                    begin
                        res_status_next = ST_DUP;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        rd_idx_next = cmp_idx_reg + CW'(1);
                        state_next  = S_SHIFT;
                    end
                end
                else if (rd_idx_reg < count_reg)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = rd_idx_reg[PW-1:0];
                    cmp_idx_next   = rd_idx_reg;
                    cmp_valid_next = 1'b1;
                    rd_idx_next    = rd_idx_reg + CW'(1);
                end
                else if (!cmp_valid_reg)
                begin
                    state_next = S_DONE;
                    if (act_reg == ACT_INSERT)
                    begin
                        if (count_reg >= CW'(CAPACITY))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en        = 1'b1;
                            wr_addr      = count_reg[PW-1:0];
                            wr_data      = key_reg;
                            count_next   = count_reg + CW'(1);
                            res_key_next = KEY_BITS'(key_reg);
                        end
                    end
                    else
                    begin
                        res_status_next = ST_NOTFOUND;
                    end
                end
            end

            S_SHIFT:
            begin
                if (cmp_valid_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = shift_dst[PW-1:0];
                    wr_data = rd_data;
                end
                if (rd_idx_reg < count_reg)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = rd_idx_reg[PW-1:0];
                    cmp_idx_next   = rd_idx_reg;
                    cmp_valid_next = 1'b1;
                    rd_idx_next    = rd_idx_reg + CW'(1);
                end
                else if (!cmp_valid_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next    = 1'b1;
                    out_key_next    = res_key_reg;
                    out_found_next  = res_found_reg;
                    out_count_next  = count_wide[COUNT_W-1:0];
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pos_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        key_reg        <= key_next;
        rd_idx_reg     <= rd_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        res_key_reg    <= res_key_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        out_key_reg    <= out_key_next;
        out_found_reg  <= out_found_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

endmodule

>>> hw/rtl/ual_ram.sv
// ual_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies

module ual_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
